// ===== rtl/sem_pkg.sv =====
`timescale 1ns / 1ps

package sem_pkg;

    // frame geometry and pixel format
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int PIXEL_BITS  = 8;
    localparam int SIZE_BITS   = 11;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
    localparam int IN_ROW_BITS = 11;

    // arithmetic widths
    localparam int GAIN_BITS     = 8;
    localparam int COLOR_BITS    = 8;
    localparam int GRAD_BITS     = PIXEL_BITS + 3;
    localparam int SQ_BITS       = 2 * GRAD_BITS - 1;
    localparam int G2_BITS       = 2 * GAIN_BITS - 2;
    localparam int SCALED_BITS   = SQ_BITS + G2_BITS;
    localparam int ROOT_BITS     = COLOR_BITS;
    localparam int RAD_BITS      = 2 * ROOT_BITS;
    localparam int ROOT_CNT_BITS = $clog2(ROOT_BITS);

    // register port
    localparam int ADDR_BITS = 4;
    localparam int DATA_BITS = 32;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_GAIN   = 2'd2;
    localparam logic [1:0] REG_MAXC   = 2'd3;

    // register reset values
    localparam logic [SIZE_BITS-1:0]  RST_WIDTH  = SIZE_BITS'(1024);
    localparam logic [SIZE_BITS-1:0]  RST_HEIGHT = SIZE_BITS'(1024);
    localparam logic [GAIN_BITS-1:0]  RST_GAIN   = GAIN_BITS'(1);
    localparam logic [COLOR_BITS-1:0] RST_MAXC   = COLOR_BITS'(255);

    // saturated frame size and scaling, as seen by the datapath
    typedef struct packed {
        logic [SIZE_BITS-1:0]         width;
        logic [SIZE_BITS-1:0]         height;
        logic signed [GAIN_BITS-1:0]  gain;
        logic [COLOR_BITS-1:0]        max_color;
    } t_cfg;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_READ  = 7'b0000010,
        ST_GRAD  = 7'b0000100,
        ST_SQR   = 7'b0001000,
        ST_SCALE = 7'b0010000,
        ST_ROOT  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } t_state;

    typedef struct packed {
        logic accept;
        logic win_update;
        logic grad_load;
        logic sq_load;
        logic scale_load;
        logic root_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic root_last;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/sobel_edge_magnitude_unit.sv =====
`timescale 1ns / 1ps
// Sobel 3x3 edge magnitude over a raster stream of grey pixels.
// Input stream: one pixel per transaction in raster order in s_axis_tdata,
// s_axis_tuser = 1 marks a drain item that carries no pixel. After each frame
// of width*height pixels send width+1 drain items to flush the last outputs.
// Output stream: edge magnitude in m_axis_tdata, m_axis_tlast on the last
// pixel of the frame. Outputs lag their pixel by one line plus one pixel.
// Registers on the APB port: frame_width at 0x0, frame_height at 0x4,
// gain at 0x8 (signed), max_color at 0xC; write them only while idle.
// An item that gives no output is accepted with the line store read and then
// updates the window; one that gives an output goes on through the gradients,
// squares, gain multiply, a bit-serial square root and the output load.
// The square root is the longest of these steps.
// A finished result waits in the output register; the next item is accepted
// meanwhile, and its result waits in the last stage while the receiver
// stalls. Reset loads the register defaults (1024 x 1024, gain 1, max 255),
// clears the window and the counters; the line stores are not cleared.

module sobel_edge_magnitude_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [7:0] pixel_value
    input  logic                          s_axis_tuser,  // [0] drain
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,  // [7:0] edge_value
    output logic                          m_axis_tlast,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sem_pkg::ADDR_BITS-1:0] paddr,
    input  logic [sem_pkg::DATA_BITS-1:0] pwdata,
    output logic [sem_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready
);

    import sem_pkg::*;

    t_cfg    cfg;
    t_cmd    cmd;
    t_status status;

    sem_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    sem_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sem_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_pixel     (s_axis_tdata[PIXEL_BITS-1:0]),
        .i_drain     (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_edge      (m_axis_tdata),
        .o_last      (m_axis_tlast)
    );

    // a result is only loaded when the output register is free
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result loaded over a pending output");

    // one item at a time: no accept right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an item is in work");

    // output valid only comes from a result load
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(cmd.out_load))
        else $error("output valid without a result");

    // input is not taken while the square root runs
    a_root_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.root_step |-> !s_axis_tready)
        else $error("input ready during square root");

endmodule

// ===== rtl/sem_ram.sv =====
`timescale 1ns / 1ps

module sem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sem_cfg.sv =====
`timescale 1ns / 1ps

module sem_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sem_pkg::ADDR_BITS-1:0] paddr,
    input  logic [sem_pkg::DATA_BITS-1:0] pwdata,
    output logic [sem_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready,
    output sem_pkg::t_cfg                 o_cfg
);

    import sem_pkg::*;

    logic [SIZE_BITS-1:0]  r_width;
    logic [SIZE_BITS-1:0]  r_height;
    logic [GAIN_BITS-1:0]  r_gain;
    logic [COLOR_BITS-1:0] r_maxc;
    logic                  wr_en;
    logic [1:0]            reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
            r_gain   <= RST_GAIN;
            r_maxc   <= RST_MAXC;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_WIDTH:  r_width  <= pwdata[SIZE_BITS-1:0];
                REG_HEIGHT: r_height <= pwdata[SIZE_BITS-1:0];
                REG_GAIN:   r_gain   <= pwdata[GAIN_BITS-1:0];
                REG_MAXC:   r_maxc   <= pwdata[COLOR_BITS-1:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (reg_idx)
            REG_WIDTH:  prdata = DATA_BITS'(r_width);
            REG_HEIGHT: prdata = DATA_BITS'(r_height);
            REG_GAIN:   prdata = DATA_BITS'(r_gain);
            REG_MAXC:   prdata = DATA_BITS'(r_maxc);
            default:    prdata = '0;
        endcase
    end

    // frame size saturates into 1..max
    always_comb begin
        if (r_width == '0) begin
            o_cfg.width = SIZE_BITS'(1);
        end else if (r_width > SIZE_BITS'(MAX_WIDTH)) begin
            o_cfg.width = SIZE_BITS'(MAX_WIDTH);
        end else begin
            o_cfg.width = r_width;
        end
        if (r_height == '0) begin
            o_cfg.height = SIZE_BITS'(1);
        end else if (r_height > SIZE_BITS'(MAX_HEIGHT)) begin
            o_cfg.height = SIZE_BITS'(MAX_HEIGHT);
        end else begin
            o_cfg.height = r_height;
        end
        o_cfg.gain      = $signed(r_gain);
        o_cfg.max_color = r_maxc;
    end

endmodule

// ===== rtl/sem_ctrl.sv =====
`timescale 1ns / 1ps

module sem_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  sem_pkg::t_status i_status,
    output sem_pkg::t_cmd    o_cmd
);

    import sem_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.win_update = 1'b1;
                n_state          = i_status.emit ? ST_GRAD : ST_IDLE;
            end
            ST_GRAD: begin
                o_cmd.grad_load = 1'b1;
                n_state         = ST_SQR;
            end
            ST_SQR: begin
                o_cmd.sq_load = 1'b1;
                n_state       = ST_SCALE;
            end
            ST_SCALE: begin
                o_cmd.scale_load = 1'b1;
                n_state          = ST_ROOT;
            end
            ST_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (i_status.root_last) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/sem_dp.sv =====
`timescale 1ns / 1ps

module sem_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sem_pkg::t_cfg                  i_cfg,
    input  sem_pkg::t_cmd                  i_cmd,
    output sem_pkg::t_status               o_status,
    input  logic [sem_pkg::PIXEL_BITS-1:0] i_pixel,
    input  logic                           i_drain,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [sem_pkg::COLOR_BITS-1:0] o_edge,
    output logic                           o_last
);

    import sem_pkg::*;

    // position counters
    logic [COL_BITS-1:0]    r_in_col;
    logic [IN_ROW_BITS-1:0] r_in_row;
    logic [COL_BITS-1:0]    r_out_col;
    logic [ROW_BITS-1:0]    r_out_row;

    // captured item
    logic [COL_BITS-1:0]   r_col;
    logic [PIXEL_BITS-1:0] r_pix;
    logic                  r_emit;

    logic [PIXEL_BITS-1:0] r_win [9];
    logic [PIXEL_BITS-1:0] up_rdata;
    logic [PIXEL_BITS-1:0] mid_rdata;

    logic signed [GRAD_BITS-1:0] r_gv;
    logic signed [GRAD_BITS-1:0] r_gh;
    logic [SQ_BITS-1:0]          r_sq;
    logic [G2_BITS-1:0]          r_g2;
    logic [SCALED_BITS-1:0]      r_scaled;
    logic [ROOT_BITS-1:0]        r_root;
    logic [ROOT_CNT_BITS-1:0]    r_bit;

    logic                  r_out_valid;
    logic [COLOR_BITS-1:0] r_edge;
    logic                  r_last;

    logic                    in_col_end;
    logic                    out_col_end;
    logic                    out_row_end;
    logic                    frame_last;
    logic                    emit_now;
    logic [PIXEL_BITS-1:0]   t [9];
    logic [PIXEL_BITS+1:0]   sum_top;
    logic [PIXEL_BITS+1:0]   sum_bot;
    logic [PIXEL_BITS+1:0]   sum_left;
    logic [PIXEL_BITS+1:0]   sum_right;
    logic signed [2*GRAD_BITS-1:0] gv2;
    logic signed [2*GRAD_BITS-1:0] gh2;
    logic signed [2*GRAD_BITS-1:0] sq_sum;
    logic signed [2*GAIN_BITS-1:0] g2_full;
    logic [ROOT_BITS-1:0]    bit_mask;
    logic [ROOT_BITS-1:0]    trial;
    logic [RAD_BITS-1:0]     trial_sq;
    logic                    gain_pos;
    logic                    root_big;
    logic [COLOR_BITS-1:0]   result;

    // line stores
    sem_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_upper (
        .i_clk   (i_clk),
        .i_we    (i_cmd.win_update),
        .i_waddr (r_col),
        .i_wdata (mid_rdata),
        .i_re    (i_cmd.accept),
        .i_raddr (r_in_col),
        .o_rdata (up_rdata)
    );

    sem_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_middle (
        .i_clk   (i_clk),
        .i_we    (i_cmd.win_update),
        .i_waddr (r_col),
        .i_wdata (r_pix),
        .i_re    (i_cmd.accept),
        .i_raddr (r_in_col),
        .o_rdata (mid_rdata)
    );

    // position compares
    assign in_col_end  = (SIZE_BITS'(r_in_col) + SIZE_BITS'(1)) >= i_cfg.width;
    assign out_col_end = (SIZE_BITS'(r_out_col) + SIZE_BITS'(1)) >= i_cfg.width;
    assign out_row_end = (SIZE_BITS'(r_out_row) + SIZE_BITS'(1)) >= i_cfg.height;
    assign frame_last  = out_row_end && out_col_end;
    assign emit_now    = (r_in_row >= IN_ROW_BITS'(2))
                      || (r_in_row == IN_ROW_BITS'(1) && r_in_col != '0);

    // item capture and position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_emit    <= 1'b0;
        end else if (i_cmd.accept) begin
            r_emit <= emit_now;
            if (in_col_end) begin
                r_in_col <= '0;
                if (r_in_row != '1) begin
                    r_in_row <= r_in_row + IN_ROW_BITS'(1);
                end
            end else begin
                r_in_col <= r_in_col + COL_BITS'(1);
            end
        end else if (i_cmd.out_load) begin
            if (frame_last) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else if (out_col_end) begin
                r_out_col <= '0;
                r_out_row <= r_out_row + ROW_BITS'(1);
            end else begin
                r_out_col <= r_out_col + COL_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_col <= r_in_col;
            r_pix <= i_drain ? '0 : i_pixel;
        end
    end

    // window shift, new column from the line stores and the captured pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else if (i_cmd.win_update) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r*3]   <= r_win[r*3+1];
                r_win[r*3+1] <= r_win[r*3+2];
            end
            r_win[2] <= up_rdata;
            r_win[5] <= mid_rdata;
            r_win[8] <= r_pix;
        end
    end

    // zero padding at the frame border
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            t[i] = r_win[i];
        end
        if (r_out_row == '0) begin
            t[0] = '0;
            t[1] = '0;
            t[2] = '0;
        end
        if (out_row_end) begin
            t[6] = '0;
            t[7] = '0;
            t[8] = '0;
        end
        if (r_out_col == '0) begin
            t[0] = '0;
            t[3] = '0;
            t[6] = '0;
        end
        if (out_col_end) begin
            t[2] = '0;
            t[5] = '0;
            t[8] = '0;
        end
    end

    // sobel sums
    assign sum_top   = {2'b00, t[0]} + {1'b0, t[1], 1'b0} + {2'b00, t[2]};
    assign sum_bot   = {2'b00, t[6]} + {1'b0, t[7], 1'b0} + {2'b00, t[8]};
    assign sum_left  = {2'b00, t[0]} + {1'b0, t[3], 1'b0} + {2'b00, t[6]};
    assign sum_right = {2'b00, t[2]} + {1'b0, t[5], 1'b0} + {2'b00, t[8]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.grad_load) begin
            r_gv <= $signed({1'b0, sum_top}) - $signed({1'b0, sum_bot});
            r_gh <= $signed({1'b0, sum_left}) - $signed({1'b0, sum_right});
        end
    end

    // squared magnitude and squared gain
    assign gv2     = r_gv * r_gv;
    assign gh2     = r_gh * r_gh;
    assign sq_sum  = gv2 + gh2;
    assign g2_full = i_cfg.gain * i_cfg.gain;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_load) begin
            r_sq <= sq_sum[SQ_BITS-1:0];
            r_g2 <= g2_full[G2_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scale_load) begin
            r_scaled <= SCALED_BITS'(r_g2) * SCALED_BITS'(r_sq);
        end
    end

    // square root, one result bit a cycle from the top
    assign bit_mask = ROOT_BITS'(1) << r_bit;
    assign trial    = r_root | bit_mask;
    assign trial_sq = RAD_BITS'(trial) * RAD_BITS'(trial);

    always_ff @(posedge i_clk) begin
        if (i_cmd.scale_load) begin
            r_root <= '0;
            r_bit  <= ROOT_CNT_BITS'(ROOT_BITS - 1);
        end else if (i_cmd.root_step) begin
            if (trial_sq <= r_scaled[RAD_BITS-1:0]) begin
                r_root <= trial;
            end
            r_bit <= r_bit - ROOT_CNT_BITS'(1);
        end
    end

    // scale, clamp
    assign gain_pos = !i_cfg.gain[GAIN_BITS-1] && (i_cfg.gain != '0);
    assign root_big = |r_scaled[SCALED_BITS-1:RAD_BITS];

    always_comb begin
        if (!gain_pos) begin
            result = '0;
        end else if (root_big || (r_root > i_cfg.max_color)) begin
            result = i_cfg.max_color;
        end else begin
            result = r_root;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_edge <= result;
            r_last <= frame_last;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_edge             = r_edge;
    assign o_last             = r_last;
    assign o_status.emit      = r_emit;
    assign o_status.root_last = (r_bit == '0);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

endmodule
